@@ sv/vbb_pkg.sv @@
// Package for the voice band-pass biquad: widths, Q14 coefficients, state
// and control types, saturation and multiply-step helpers.
// No dependencies.
`default_nettype none

package vbb_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int STATE_W   = 40;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 14;

    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int Y_W    = ((PROD_W > STATE_W) ? PROD_W : STATE_W) + 1;
    localparam int P_W    = Y_W + 2;
    localparam int D_W    = P_W + 1;
    localparam int Q_W    = Y_W - COEF_FRAC;
    localparam int CNT_W  = $clog2(COEF_W);

    localparam logic signed [COEF_W-1:0] C_B0 = 16'sd1106;
    localparam logic signed [COEF_W-1:0] C_B2 = -16'sd1106;
    localparam logic signed [COEF_W-1:0] C_A1 = -16'sd18725;
    localparam logic signed [COEF_W-1:0] C_A2 = 16'sd15671;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic step;
        logic commit;
    } t_ctrl;

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [D_W-1:0] v
    );
        logic signed [D_W-1:0] hi;
        logic signed [D_W-1:0] lo;
        hi = {{(D_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return hi[STATE_W-1:0];
        end else if (v < lo) begin
            return lo[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip_sample(
        input logic signed [Q_W-1:0] q
    );
        logic signed [Q_W-1:0] hi;
        logic signed [Q_W-1:0] lo;
        hi = {{(Q_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
        lo = ~hi;
        if (q > hi) begin
            return hi[SAMPLE_W-1:0];
        end else if (q < lo) begin
            return lo[SAMPLE_W-1:0];
        end
        return q[SAMPLE_W-1:0];
    endfunction

    // One radix-2 step of the serial-parallel multiply; halve drops the
    // low bit, which keeps the result floored.
    function automatic logic signed [P_W-1:0] mac_step(
        input logic signed [P_W-1:0] acc,
        input logic signed [P_W-1:0] mcand,
        input logic                  cbit,
        input logic                  negate,
        input logic                  halve
    );
        logic signed [D_W-1:0] addend;
        logic signed [D_W-1:0] sum;
        addend = cbit ? D_W'(mcand) : '0;
        sum    = negate ? (D_W'(acc) - addend) : (D_W'(acc) + addend);
        return halve ? sum[P_W:1] : sum[P_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/voice_bandpass_biquad.sv @@
// Voice band-pass biquad, transposed direct form II, fixed Q14 coefficients.
// Depends on vbb_pkg.
//
// Input channel: i_in_valid / o_in_ready carry i_sample_in and
// i_last_of_block. Output channel: o_out_valid / i_out_ready carry
// o_sample_out and o_last_out, one result per input transfer.
// A transfer loads y = b0*x + state; the two feedback products a1*y and a2*y
// are then formed by a serial-parallel multiplier that takes one coefficient
// bit per cycle from a 16-step coefficient shift register, and a done state
// updates both 40-bit states and loads the output register. A new input is
// taken only in the idle state, after the previous item has been committed.
// The output register lets the next item be taken and worked on while a
// result waits; if it is still full when the next result is ready, the block
// holds in its done state until the receiver takes the waiting result.
// Reset (synchronous, active low) clears both states, the sequencer and the
// output valid. States also clear after an item marked last of block.
`default_nettype none

module voice_bandpass_biquad import vbb_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output      logic                       o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_in,
    input  wire logic                       i_last_of_block,
    output      logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    output      logic signed [SAMPLE_W-1:0] o_sample_out,
    output      logic                       o_last_out
);

    t_state                      r_state;
    t_state                      n_state;
    t_ctrl                       ctrl;
    logic                        accept;
    logic [CNT_W-1:0]            r_cnt;
    logic                        step_last;
    logic                        step_shift;

    logic signed [STATE_W-1:0]   r_d1;
    logic signed [STATE_W-1:0]   r_d2;
    logic signed [STATE_W-1:0]   n_d1;
    logic signed [STATE_W-1:0]   n_d2;

    logic signed [PROD_W-1:0]    b0x_in;
    logic signed [PROD_W-1:0]    b2x_in;
    logic signed [Y_W-1:0]       y_in;
    logic signed [Y_W-1:0]       r_y;
    logic signed [PROD_W-1:0]    r_b2x;
    logic                        r_last;

    logic signed [P_W-1:0]       r_mcand;
    logic signed [P_W-1:0]       r_acc1;
    logic signed [P_W-1:0]       r_acc2;
    logic [COEF_W-1:0]           r_coef1;
    logic [COEF_W-1:0]           r_coef2;

    logic signed [Y_W-1:0]       y_adj;
    logic signed [Q_W-1:0]       q_trunc;
    logic signed [SAMPLE_W-1:0]  n_sample_out;
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_sample_out;
    logic                        r_last_out;

    assign accept     = i_in_valid & ctrl.in_ready;
    assign step_last  = (r_cnt == CNT_W'(COEF_W - 1));
    assign step_shift = (r_cnt < CNT_W'(COEF_FRAC));

    assign b0x_in = C_B0 * i_sample_in;
    assign b2x_in = C_B2 * i_sample_in;
    assign y_in   = Y_W'(b0x_in) + Y_W'(r_d1);

    assign n_d1 = sat_state(D_W'(r_d2) - D_W'(r_acc1));
    assign n_d2 = sat_state(D_W'(r_b2x) - D_W'(r_acc2));

    assign y_adj        = r_y + (r_y[Y_W-1] ? Y_W'((1 << COEF_FRAC) - 1) : '0);
    assign q_trunc      = y_adj[Y_W-1:COEF_FRAC];
    assign n_sample_out = clip_sample(q_trunc);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (step_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (ctrl.commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (r_state)
            ST_IDLE: ctrl.in_ready = 1'b1;
            ST_MUL:  ctrl.step     = 1'b1;
            ST_DONE: ctrl.commit   = ~r_out_valid | i_out_ready;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_d1        <= '0;
            r_d2        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= ctrl.commit | (r_out_valid & ~i_out_ready);
            if (accept) begin
                r_cnt <= '0;
            end else if (ctrl.step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (ctrl.commit) begin
                r_d1 <= r_last ? '0 : n_d1;
                r_d2 <= r_last ? '0 : n_d2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_y     <= y_in;
            r_b2x   <= b2x_in;
            r_last  <= i_last_of_block;
            r_mcand <= P_W'(y_in);
            r_acc1  <= '0;
            r_acc2  <= '0;
            r_coef1 <= C_A1;
            r_coef2 <= C_A2;
        end else if (ctrl.step) begin
            r_acc1  <= mac_step(r_acc1, r_mcand, r_coef1[0], step_last, step_shift);
            r_acc2  <= mac_step(r_acc2, r_mcand, r_coef2[0], step_last, step_shift);
            r_coef1 <= r_coef1 >> 1;
            r_coef2 <= r_coef2 >> 1;
            if (!step_shift) begin
                r_mcand <= r_mcand <<< 1;
            end
        end
        if (ctrl.commit) begin
            r_sample_out <= n_sample_out;
            r_last_out   <= r_last;
        end
    end

    assign o_in_ready   = ctrl.in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_last_out   = r_last_out;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_MUL) && (r_cnt == '0))
        else $error("transfer did not start the multiply");

    a_mul_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) && step_last |=> (r_state == ST_DONE))
        else $error("multiply overran its step count");

    a_commit_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.commit |=> o_out_valid && (r_state == ST_IDLE))
        else $error("result not held after commit");

    a_block_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.commit && r_last |=> (r_d1 == '0) && (r_d2 == '0))
        else $error("states not cleared after last of block");
`endif

endmodule

`default_nettype wire

@@ dv/vbb_checker.sv @@
// Checker for the voice band-pass biquad: watches both channels, predicts each
// filtered sample in Q14 fixed point and compares it with the block's output.
// Depends on vbb_pkg for the sample and state widths.
`timescale 1ns / 1ps

module vbb_checker import vbb_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_in,
    input  wire logic                       i_last_in,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_out,
    input  wire logic                       i_last_out,
    output int                              o_pending,
    output int                              o_fail_count
);

    localparam int     FRAC     = 14;
    localparam longint Q_ONE    = longint'(1) << FRAC;
    localparam longint K_B0     = 1106;
    localparam longint K_B2     = -1106;
    localparam longint K_A1     = -18725;
    localparam longint K_A2     = 15671;
    localparam longint ACC_MAX  = (longint'(1) << (STATE_W - 1)) - 1;
    localparam longint ACC_MIN  = -ACC_MAX - 1;
    localparam longint PCM_MAX  = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint PCM_MIN  = -PCM_MAX - 1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } filt_sample_t;

    filt_sample_t expected_samples[$];
    filt_sample_t want;
    longint       acc_first  = 0;
    longint       acc_second = 0;
    int           faults     = 0;

    assign o_fail_count = faults;

    function automatic longint clamp_acc(input longint v);
        if (v > ACC_MAX) begin
            return ACC_MAX;
        end else if (v < ACC_MIN) begin
            return ACC_MIN;
        end
        return v;
    endfunction

    function automatic filt_sample_t filter_sample(
        input logic signed [SAMPLE_W-1:0] x_in,
        input logic                       last
    );
        longint       x;
        longint       y;
        longint       q;
        filt_sample_t res;
        x = longint'(x_in);
        y = K_B0 * x + acc_first;
        acc_first  = clamp_acc(acc_second - ((K_A1 * y) >>> FRAC));
        acc_second = clamp_acc(K_B2 * x - ((K_A2 * y) >>> FRAC));
        q = y / Q_ONE;
        if (q > PCM_MAX) begin
            q = PCM_MAX;
        end else if (q < PCM_MIN) begin
            q = PCM_MIN;
        end
        res.sample = q[SAMPLE_W-1:0];
        res.last   = last;
        if (last) begin
            acc_first  = 0;
            acc_second = 0;
        end
        return res;
    endfunction

    task automatic log_fault(input string msg);
        faults++;
        if (faults <= 10) begin
            $display("%t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_first  = 0;
            acc_second = 0;
            expected_samples.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    log_fault($sformatf("unexpected output transfer: sample %0d last %0b",
                        i_sample_out, i_last_out));
                end else begin
                    want = expected_samples.pop_front();
                    if (want.sample !== i_sample_out || want.last !== i_last_out) begin
                        log_fault($sformatf(
                            "mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                            $signed(want.sample), want.last, i_sample_out, i_last_out));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_samples.push_back(filter_sample(i_sample_in, i_last_in));
            end
        end
        o_pending <= expected_samples.size();
    end

endmodule

@@ dv/tb.sv @@
// Testbench top for voice_bandpass_biquad: drives bursts of audio samples and
// a stalling receiver, and reports the verdict from vbb_checker.
// Depends on vbb_pkg, voice_bandpass_biquad and vbb_checker.
`timescale 1ns / 1ps

module tb import vbb_pkg::*;;

    localparam int RESET_CYCLES = 11;
    localparam int TOTAL_ITEMS  = 1150;
    localparam int PRESSURE_AT  = 500;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 40;

    typedef enum int {
        BLK_NOISE,
        BLK_TONE,
        BLK_QUIET,
        BLK_FULL_TONE
    } blk_kind_t;

    typedef enum int {
        RX_OPEN,
        RX_HOLD,
        RX_RANDOM,
        RX_RANDOM_ALT
    } rx_mode_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       last_in   = 1'b0;
    logic                       out_ready = 1'b0;
    logic                       in_ready;
    logic                       out_valid;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
    int                         pending;
    int                         fail_count;

    int       sent        = 0;
    int       burst_left  = 0;
    int       idle_cycles = 0;
    int       rx_left     = 0;
    rx_mode_t rx_mode     = RX_OPEN;

    always #5 clk = ~clk;

    voice_bandpass_biquad i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_sample_in     (sample_in),
        .i_last_of_block (last_in),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_sample_out    (sample_out),
        .o_last_out      (last_out)
    );

    vbb_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_sample_in  (sample_in),
        .i_last_in    (last_in),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_sample_out (sample_out),
        .i_last_out   (last_out),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(1, 80);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_OPEN: begin
                out_ready <= 1'b1;
            end
            RX_HOLD: begin
                out_ready <= 1'b0;
            end
            default: begin
                out_ready <= 1'($urandom_range(0, 1));
            end
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
        in_valid  <= 1'b1;
        sample_in <= s;
        last_in   <= last;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        sent++;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] square_at(
        input int k,
        input int half,
        input int amp
    );
        if (((k / half) % 2) != 0) begin
            return (amp >= 32767) ? -16'sd32768 : SAMPLE_W'(-amp);
        end
        return SAMPLE_W'(amp);
    endfunction

    initial begin
        blk_kind_t                  kind;
        int                         len;
        int                         amp;
        int                         phase;
        int                         half;
        logic signed [SAMPLE_W-1:0] s;
        logic                       last;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_sample(16'sd0, 1'b0);
        push_sample(16'sd32767, 1'b0);
        push_sample(-16'sd32768, 1'b0);
        push_sample(-16'sd1, 1'b1);
        push_sample(16'sh5555, 1'b0);
        push_sample(16'shAAAA, 1'b1);
        // drive the resonance with a full-scale square wave as one block
        for (int k = 0; k < 19; k++) begin
            push_sample(square_at(k, 3, 32767), k == 18);
        end
        drain();

        while (sent < TOTAL_ITEMS) begin
            kind  = blk_kind_t'($urandom_range(0, 3));
            len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
            amp   = $urandom_range(0, 32767);
            phase = $urandom_range(0, 9);
            half  = $urandom_range(2, 5);
            for (int k = 0; k < len; k++) begin
                case (kind)
                    BLK_NOISE: begin
                        s = SAMPLE_W'($urandom);
                    end
                    BLK_TONE: begin
                        s = square_at(k + phase, half, amp);
                    end
                    BLK_QUIET: begin
                        s = SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
                    end
                    default: begin
                        s = square_at(k + phase, 3, 32767);
                    end
                endcase
                last = (k == len - 1) ? ($urandom_range(0, 4) != 0)
                                      : ($urandom_range(0, 40) == 0);
                push_sample(s, last);
                if (sent == PRESSURE_AT) begin
                    drain();
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
